[rtl/wrd_pkg.sv]
// shared types and constants of the windowed rms decimator
package wrd_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned SquareW   = 31;
  localparam int unsigned SumW      = 46;
  localparam int unsigned CountW    = 16;
  localparam int unsigned InvW      = 17;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned HalfW     = 23;
  localparam int unsigned PartW     = HalfW + InvW;
  localparam int unsigned ProdW     = SumW + InvW;
  localparam int unsigned MeanShift = 16;
  localparam int unsigned MeanW     = ProdW - MeanShift;
  localparam int unsigned RmsW      = 16;
  localparam int unsigned RmsMax    = 32768;
  localparam int unsigned RootSteps = 24;
  localparam int unsigned StepCntW  = 5;

  localparam logic [CfgIdxW-1:0] CfgWindowLen  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvDensity = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPointLimit = 2'd2;

  typedef struct packed {
    logic load_sample;
    logic accumulate;
    logic mul_lo;
    logic mul_hi;
    logic root_init;
    logic root_step;
    logic out_load;
  } wrd_cmd_t;

  typedef struct packed {
    logic close;
    logic out_free;
  } wrd_status_t;

endpackage

[rtl/wrd_ctrl.sv]
// sequencer for accumulation, split multiply, iterative square root and output load
module wrd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wrd_pkg::wrd_status_t status_i,
  output wrd_pkg::wrd_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StAcc      = 3'd1;
  localparam logic [2:0] StMulLo    = 3'd2;
  localparam logic [2:0] StMulHi    = 3'd3;
  localparam logic [2:0] StRootInit = 3'd4;
  localparam logic [2:0] StRoot     = 3'd5;
  localparam logic [2:0] StEmit     = 3'd6;

  localparam logic [wrd_pkg::StepCntW-1:0] LastStep =
    wrd_pkg::StepCntW'(wrd_pkg::RootSteps - 1);

  logic [2:0]                     state_q, state_d;
  logic [wrd_pkg::StepCntW-1:0]   step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = StAcc;
        end
      end
      StAcc: begin
        cmd_o.accumulate = 1'b1;
        state_d          = status_i.close ? StMulLo : StIdle;
      end
      StMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = StMulHi;
      end
      StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StRootInit;
      end
      StRootInit: begin
        cmd_o.root_init = 1'b1;
        step_d          = '0;
        state_d         = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[rtl/wrd_datapath.sv]
// configuration, window accumulator, split multiplier, square root and output register
module wrd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [wrd_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic signed [wrd_pkg::SampleW-1:0] sample_i,
  input  logic                              channel_end_i,
  input  wrd_pkg::wrd_cmd_t                 cmd_i,
  output wrd_pkg::wrd_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wrd_pkg::RmsW-1:0]          rms_value_o,
  output logic                              last_point_o
);

  localparam int unsigned CountW = wrd_pkg::CountW;
  localparam int unsigned MeanW  = wrd_pkg::MeanW;

  logic [CountW-1:0]          window_len_q;
  logic [wrd_pkg::InvW-1:0]   inv_density_q;
  logic [CountW-1:0]          point_limit_q;

  logic [wrd_pkg::SquareW-1:0] square_q;
  logic                        end_q;
  logic                        pend_end_q;
  logic                        last_q;
  logic [wrd_pkg::SumW-1:0]    sum_q;
  logic [CountW-1:0]           count_q;
  logic [CountW-1:0]           points_q;
  logic [wrd_pkg::PartW-1:0]   part_lo_q;
  logic [wrd_pkg::PartW-1:0]   part_hi_q;
  logic [MeanW-1:0]            rem_q;
  logic [MeanW-1:0]            root_q;
  logic [MeanW-1:0]            bit_q;
  logic                        out_valid_q;
  logic [wrd_pkg::RmsW-1:0]    rms_q;
  logic                        out_last_q;

  logic signed [2*wrd_pkg::SampleW-1:0] sq_full;
  logic [CountW-1:0]           len_eff;
  logic [CountW-1:0]           count_inc;
  logic [CountW-1:0]           points_inc;
  logic                        active;
  logic [wrd_pkg::SumW-1:0]    sum_inc;
  logic [wrd_pkg::ProdW-1:0]   prod;
  logic [MeanW:0]              trial;
  logic                        take;

  assign sq_full    = (2*wrd_pkg::SampleW)'(sample_i) * (2*wrd_pkg::SampleW)'(sample_i);
  assign len_eff    = (window_len_q == '0) ? CountW'(1) : window_len_q;
  assign count_inc  = count_q + 1'b1;
  assign points_inc = points_q + 1'b1;
  assign active     = points_q < point_limit_q;
  assign sum_inc    = sum_q + wrd_pkg::SumW'(square_q);

  assign status_o.close    = active && (count_inc >= len_eff);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign prod  = wrd_pkg::ProdW'(part_lo_q)
               + (wrd_pkg::ProdW'(part_hi_q) << wrd_pkg::HalfW);
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign take  = {1'b0, rem_q} >= trial;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q  <= CountW'(1);
      inv_density_q <= wrd_pkg::InvW'(65536);
      point_limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wrd_pkg::CfgWindowLen:  window_len_q  <= cfg_data_i[CountW-1:0];
        wrd_pkg::CfgInvDensity: inv_density_q <= cfg_data_i;
        wrd_pkg::CfgPointLimit: point_limit_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // window and channel counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      count_q    <= '0;
      points_q   <= '0;
      pend_end_q <= 1'b0;
      last_q     <= 1'b0;
    end else if (cmd_i.accumulate) begin
      if (status_o.close) begin
        sum_q      <= sum_inc;
        count_q    <= count_inc;
        points_q   <= points_inc;
        last_q     <= points_inc == point_limit_q;
        pend_end_q <= end_q;
      end else if (end_q) begin
        sum_q    <= '0;
        count_q  <= '0;
        points_q <= '0;
      end else if (active) begin
        sum_q   <= sum_inc;
        count_q <= count_inc;
      end
    end else if (cmd_i.root_init) begin
      // closed window has been read by the multiplier
      sum_q   <= '0;
      count_q <= '0;
      if (pend_end_q) begin
        points_q <= '0;
      end
    end
  end

  // sample square, multiplier halves and square root
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      square_q <= sq_full[wrd_pkg::SquareW-1:0];
      end_q    <= channel_end_i;
    end
    if (cmd_i.mul_lo) begin
      part_lo_q <= wrd_pkg::PartW'(sum_q[wrd_pkg::HalfW-1:0]) * wrd_pkg::PartW'(inv_density_q);
    end
    if (cmd_i.mul_hi) begin
      part_hi_q <= wrd_pkg::PartW'(sum_q[wrd_pkg::SumW-1:wrd_pkg::HalfW])
                 * wrd_pkg::PartW'(inv_density_q);
    end
    if (cmd_i.root_init) begin
      rem_q  <= prod[wrd_pkg::ProdW-1:wrd_pkg::MeanShift];
      root_q <= '0;
      bit_q  <= MeanW'(1) << (MeanW - 1);
    end else if (cmd_i.root_step) begin
      if (take) begin
        rem_q  <= rem_q - trial[MeanW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rms_q      <= (root_q > MeanW'(wrd_pkg::RmsMax)) ? wrd_pkg::RmsW'(wrd_pkg::RmsMax)
                                                      : root_q[wrd_pkg::RmsW-1:0];
      out_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rms_value_o  = rms_q;
  assign last_point_o = out_last_q;

endmodule

[rtl/windowed_rms_decimator_unit.sv]
// windowed rms decimator top level
// a sample that does not close a window is accepted, then accumulated
// a sample that closes a window goes on to its result through accumulate, two
// multiply halves, root setup, 24 square root steps of one result bit each, output load
// the next sample is accepted once the result sits in the output register
// reset is asynchronous, active low; it clears counters, sums and the output valid
module windowed_rms_decimator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wrd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [wrd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [wrd_pkg::SampleW-1:0] sample_i,
  input  logic                               channel_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [wrd_pkg::RmsW-1:0]           rms_value_o,
  output logic                               last_point_o
);

  wrd_pkg::wrd_cmd_t    cmd;
  wrd_pkg::wrd_status_t status;

  wrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wrd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .channel_end_i (channel_end_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rms_value_o   (rms_value_o),
    .last_point_o  (last_point_o)
  );

endmodule
